FILE: rtl/core/burst_fragment_reassembler_macros.svh
// Assertion macros shared by the checker file.
`ifndef BURST_FRAGMENT_REASSEMBLER_MACROS_SVH
`define BURST_FRAGMENT_REASSEMBLER_MACROS_SVH

// Property checked at every clock edge while reset is released.
`define BFR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define BFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/bfr_pkg.sv
package bfr_pkg;

  localparam int CAPTURE_DEPTH = 1024;
  localparam int QUEUE_SLOTS   = 4;
  localparam int NUM_BANKS     = QUEUE_SLOTS + 1;
  localparam int IDX_W         = 10;
  localparam int CNT_W         = 11;
  localparam int BANK_W        = 3;
  localparam int ADDR_W        = BANK_W + IDX_W;
  localparam int QPTR_W        = 2;
  localparam int FILL_W        = 3;
  localparam int HDR_BYTES     = 6;

  // Command codes
  localparam logic [2:0] CMD_HDR = 3'd0;
  localparam logic [2:0] CMD_SMP = 3'd1;
  localparam logic [2:0] CMD_RD  = 3'd2;
  localparam logic [2:0] CMD_REL = 3'd3;
  localparam logic [2:0] CMD_ABT = 3'd4;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic [2:0]        cmd;
    logic              bad;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  start;
    logic [CNT_W-1:0]  count;
    logic signed [15:0] pa;
    logic signed [15:0] pb;
    logic [15:0]       ang;
    logic [IDX_W-1:0]  idx;
  } op_t;

  // One result beat
  typedef struct packed {
    logic [31:0]        frm_total;
    logic [31:0]        err_total;
    logic [CNT_W-1:0]   rcvd;
    logic [CNT_W-1:0]   oldest_len;
    logic [FILL_W-1:0]  queued;
    logic               read_valid;
    logic [15:0]        ang;
    logic signed [15:0] pb;
    logic signed [15:0] pa;
    logic               dropped;
    logic               done;
    logic               perr;
  } res_t;

  // Status of the back part seen by the top level
  typedef struct packed {
    logic sweeping;
  } bk_stat_t;

endpackage

FILE: rtl/core/burst_fragment_reassembler.sv
// Fragment reassembler for current and angle captures.
// Input stream: in_tuser carries the command (header, sample, read, release,
// abort), in_tdata the header, sample and read fields. Every accepted beat gives
// exactly one result beat on the output stream carrying flags, read data and
// status after that item. The queue limit is written through cfg_wr_en/cfg_wr_data.
// Items pass a two-entry queue from the classifying front to the executing back.
// Header, release and abort finish in the back directly; sample and read pass
// an extra state, set by the registered read port of the sample store and
// presence map (one read-modify-write per sample). The result is registered,
// and the back takes no new item from the queue while it is busy with one.
// After reset, on a change of capture total, on a completed capture and on abort
// the presence map is cleared one entry per cycle over all its entries, while
// in_tready is low. The reset pass runs before the first item is taken.
// When the receiver stalls, the result register holds and the back stops; the
// queue then fills and in_tready drops.
module burst_fragment_reassembler (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_wr_data,   // queue_limit
  input  logic         in_tvalid,
  output logic         in_tready,
  // burst_total, frame_start, frame_count, payload_bytes, phase_a, phase_b,
  // rotor_angle, read_index, zero fill
  input  logic [127:0] in_tdata,
  input  logic [2:0]   in_tuser,      // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  // parse_error, burst_done, burst_dropped, out_phase_a, out_phase_b, out_angle,
  // read_valid, queued_captures, oldest_length, received_so_far, error_total,
  // frame_total, zero fill
  output logic [143:0] out_tdata
);

  bfr_pkg::op_t      fr_op;
  bfr_pkg::op_t      q_op;
  bfr_pkg::bk_stat_t bk_stat;
  bfr_pkg::res_t     res;
  logic              q_full, q_valid, q_pop, push;

  assign in_tready = !q_full && !bk_stat.sweeping;
  assign push      = in_tvalid && in_tready;

  bfr_front u_front (
    .cmd  (in_tuser),
    .data (in_tdata),
    .op   (fr_op)
  );

  bfr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (fr_op),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .pop_op  (q_op)
  );

  bfr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_op        (q_op),
    .q_pop       (q_pop),
    .stat        (bk_stat),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res)
  );

  assign out_tdata = {3'b000, res};

endmodule

FILE: rtl/core/bfr_front.sv
module bfr_front (
  input  logic [2:0]    cmd,
  input  logic [127:0]  data,
  output bfr_pkg::op_t  op
);

  logic [15:0] total;
  logic [15:0] start;
  logic [15:0] count;
  logic [15:0] size;
  logic [18:0] expected;
  logic [16:0] span;
  logic        bad;

  // Header field extraction and size checks
  always_comb begin
    total    = data[15:0];
    start    = data[31:16];
    count    = data[47:32];
    size     = data[63:48];
    expected = 19'(bfr_pkg::HDR_BYTES) + {1'b0, count, 2'b00} + {2'b00, count, 1'b0};
    span     = {1'b0, start} + {1'b0, count};
    bad      = (total == 16'd0) || (count == 16'd0) || (expected > {3'b000, size}) ||
               (span > {1'b0, total}) || (total > 16'(bfr_pkg::CAPTURE_DEPTH));
  end

  // Pack the classified item
  always_comb begin
    op.cmd   = cmd;
    op.bad   = bad;
    op.total = total[bfr_pkg::CNT_W-1:0];
    op.start = start[bfr_pkg::CNT_W-1:0];
    op.count = count[bfr_pkg::CNT_W-1:0];
    op.pa    = data[79:64];
    op.pb    = data[95:80];
    op.ang   = data[111:96];
    op.idx   = data[121:112];
  end

endmodule

FILE: rtl/core/bfr_queue.sv
module bfr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bfr_pkg::op_t  push_op,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output bfr_pkg::op_t  pop_op
);

  bfr_pkg::op_t ent_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  // Pointer and occupancy update
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_op;
    end
  end

  assign full   = (cnt_r == 2'd2);
  assign valid  = (cnt_r != 2'd0);
  assign pop_op = ent_r[rp_r];

endmodule

FILE: rtl/core/bfr_back.sv
module bfr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_wr_data,
  input  logic              q_valid,
  input  bfr_pkg::op_t      q_op,
  output logic              q_pop,
  output bfr_pkg::bk_stat_t stat,
  output logic              res_valid,
  input  logic              res_ready,
  output bfr_pkg::res_t     res
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_SMP   = 2'd2;
  localparam logic [1:0] ST_RD    = 2'd3;

  localparam int CW = bfr_pkg::CNT_W;
  localparam int IW = bfr_pkg::IDX_W;
  localparam int BW = bfr_pkg::BANK_W;
  localparam int QW = bfr_pkg::QPTR_W;
  localparam int FW = bfr_pkg::FILL_W;

  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] sweep_r, sweep_nxt;
  logic [2:0]    limit_r;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] rc_r, rc_nxt;
  logic [CW-1:0] base_r, base_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          acc_r, acc_nxt;
  logic [BW-1:0] bank_r, bank_nxt;
  logic [BW-1:0] qbank_r [bfr_pkg::QUEUE_SLOTS];
  logic [BW-1:0] qbank_nxt [bfr_pkg::QUEUE_SLOTS];
  logic [CW-1:0] qlen_r [bfr_pkg::QUEUE_SLOTS];
  logic [CW-1:0] qlen_nxt [bfr_pkg::QUEUE_SLOTS];
  logic [QW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [31:0]   err_r, err_nxt;
  logic [31:0]   frm_r, frm_nxt;
  logic          hit_r, hit_nxt;
  bfr_pkg::res_t out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Sample store and presence map
  logic [47:0]       store_mem [bfr_pkg::NUM_BANKS * bfr_pkg::CAPTURE_DEPTH];
  logic [47:0]       store_q_r;
  logic              store_we, store_re;
  logic [bfr_pkg::ADDR_W-1:0] store_waddr, store_raddr;
  logic [47:0]       store_wdata;
  logic              pmap_mem [bfr_pkg::CAPTURE_DEPTH];
  logic              pmap_q_r;
  logic              pmap_we, pmap_re, pmap_wdata;
  logic [IW-1:0]     pmap_waddr, pmap_raddr;

  logic [FW-1:0] limit;
  logic          out_free;
  logic          fin, go_sweep, perr, done, dropped, hit;
  logic [CW-1:0] rc_t;
  logic [QW-1:0] pos, qi;
  logic [FW-1:0] f_t;
  logic          used, found;

  // Queue limit clamped to 1..QUEUE_SLOTS
  always_comb begin
    if (limit_r == 3'd0) begin
      limit = 3'd1;
    end else if (limit_r > 3'(bfr_pkg::QUEUE_SLOTS)) begin
      limit = 3'(bfr_pkg::QUEUE_SLOTS);
    end else begin
      limit = limit_r;
    end
  end

  assign out_free = !out_valid_r || res_ready;
  assign q_pop    = (state_r == ST_IDLE) && q_valid && out_free;

  // Command execution
  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    len_nxt   = len_r;
    rc_nxt    = rc_r;
    base_nxt  = base_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    bank_nxt  = bank_r;
    qbank_nxt = qbank_r;
    qlen_nxt  = qlen_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    err_nxt   = err_r;
    frm_nxt   = frm_r;
    hit_nxt   = hit_r;
    fin       = 1'b0;
    go_sweep  = 1'b0;
    perr      = 1'b0;
    done      = 1'b0;
    dropped   = 1'b0;
    hit       = 1'b0;
    rc_t      = rc_r;
    pos       = '0;
    f_t       = fill_r;
    used      = 1'b0;
    found     = 1'b0;
    qi        = '0;
    store_we    = 1'b0;
    store_waddr = {bank_r, base_r[IW-1:0]};
    store_wdata = {q_op.ang, q_op.pb, q_op.pa};
    store_re    = 1'b0;
    store_raddr = {qbank_r[head_r], q_op.idx};
    pmap_we     = 1'b0;
    pmap_waddr  = sweep_r;
    pmap_wdata  = 1'b0;
    pmap_re     = 1'b0;
    pmap_raddr  = base_r[IW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          case (q_op.cmd)
            bfr_pkg::CMD_HDR: begin
              frm_nxt = frm_r + 32'd1;
              fin     = 1'b1;
              if (q_op.bad) begin
                err_nxt = err_r + 32'd1;
                perr    = 1'b1;
                acc_nxt = 1'b0;
                rem_nxt = '0;
              end else begin
                if (len_r != q_op.total) begin
                  len_nxt  = q_op.total;
                  rc_nxt   = '0;
                  go_sweep = 1'b1;
                end
                base_nxt = q_op.start;
                rem_nxt  = q_op.count;
                acc_nxt  = 1'b1;
              end
            end
            bfr_pkg::CMD_SMP: begin
              if (acc_r && (rem_r != '0) && (base_r < CW'(bfr_pkg::CAPTURE_DEPTH))) begin
                store_we  = 1'b1;
                pmap_re   = 1'b1;
                state_nxt = ST_SMP;
              end else begin
                fin = 1'b1;
              end
            end
            bfr_pkg::CMD_RD: begin
              hit       = (fill_r != '0) && ({1'b0, q_op.idx} < qlen_r[head_r]);
              hit_nxt   = hit;
              store_re  = 1'b1;
              state_nxt = ST_RD;
            end
            bfr_pkg::CMD_REL: begin
              fin = 1'b1;
              if (fill_r != '0) begin
                head_nxt = head_r + QW'(1);
                fill_nxt = fill_r - FW'(1);
              end
            end
            bfr_pkg::CMD_ABT: begin
              fin      = 1'b1;
              go_sweep = 1'b1;
              len_nxt  = '0;
              rc_nxt   = '0;
              base_nxt = '0;
              rem_nxt  = '0;
              acc_nxt  = 1'b0;
              head_nxt = '0;
              fill_nxt = '0;
              bank_nxt = '0;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_SMP: begin
        // Second half of the sample read-modify-write
        fin        = 1'b1;
        state_nxt  = ST_IDLE;
        rc_t       = pmap_q_r ? rc_r : rc_r + CW'(1);
        rc_nxt     = rc_t;
        pmap_we    = 1'b1;
        pmap_waddr = base_r[IW-1:0];
        pmap_wdata = 1'b1;
        base_nxt   = base_r + CW'(1);
        rem_nxt    = rem_r - CW'(1);
        if (rem_nxt == '0) begin
          acc_nxt = 1'b0;
          if (rc_t == len_r) begin
            // Capture complete: queue it, dropping the oldest if full
            if (fill_r >= limit) begin
              head_nxt = head_r + QW'(1);
              f_t      = fill_r - FW'(1);
              dropped  = 1'b1;
            end
            pos            = head_nxt + f_t[QW-1:0];
            qbank_nxt[pos] = bank_r;
            qlen_nxt[pos]  = len_r;
            fill_nxt       = f_t + FW'(1);
            done           = 1'b1;
            len_nxt        = '0;
            rc_nxt         = '0;
            go_sweep       = 1'b1;
            // Lowest bank not held by a queued capture
            bank_nxt = '0;
            for (int b = 0; b < bfr_pkg::NUM_BANKS; b++) begin
              used = 1'b0;
              for (int i = 0; i < bfr_pkg::QUEUE_SLOTS; i++) begin
                qi = head_nxt + QW'(i);
                if ((FW'(i) < fill_nxt) && (qbank_nxt[qi] == BW'(b))) begin
                  used = 1'b1;
                end
              end
              if (!used && !found) begin
                bank_nxt = BW'(b);
                found    = 1'b1;
              end
            end
          end
        end
      end
      ST_RD: begin
        fin       = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SWEEP: begin
        // Clear one presence bit per cycle
        pmap_we    = 1'b1;
        pmap_waddr = sweep_r;
        pmap_wdata = 1'b0;
        sweep_nxt  = sweep_r + IW'(1);
        if (sweep_r == IW'(bfr_pkg::CAPTURE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (go_sweep) begin
      state_nxt = ST_SWEEP;
      sweep_nxt = '0;
    end
  end

  // Result assembly from the updated status
  always_comb begin
    out_nxt            = out_r;
    out_valid_nxt      = out_valid_r && !res_ready;
    if (fin) begin
      out_valid_nxt      = 1'b1;
      out_nxt.perr       = perr;
      out_nxt.done       = done;
      out_nxt.dropped    = dropped;
      out_nxt.read_valid = (state_r == ST_RD) && hit_r;
      out_nxt.pa         = out_nxt.read_valid ? store_q_r[15:0] : 16'd0;
      out_nxt.pb         = out_nxt.read_valid ? store_q_r[31:16] : 16'd0;
      out_nxt.ang        = out_nxt.read_valid ? store_q_r[47:32] : 16'd0;
      out_nxt.queued     = fill_nxt;
      out_nxt.oldest_len = (fill_nxt != '0) ? qlen_nxt[head_nxt] : '0;
      out_nxt.rcvd       = rc_nxt;
      out_nxt.err_total  = err_nxt;
      out_nxt.frm_total  = frm_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_r     <= '0;
      limit_r     <= 3'(bfr_pkg::QUEUE_SLOTS);
      len_r       <= '0;
      rc_r        <= '0;
      base_r      <= '0;
      rem_r       <= '0;
      acc_r       <= 1'b0;
      bank_r      <= '0;
      head_r      <= '0;
      fill_r      <= '0;
      err_r       <= '0;
      frm_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      len_r       <= len_nxt;
      rc_r        <= rc_nxt;
      base_r      <= base_nxt;
      rem_r       <= rem_nxt;
      acc_r       <= acc_nxt;
      bank_r      <= bank_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      err_r       <= err_nxt;
      frm_r       <= frm_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    qbank_r <= qbank_nxt;
    qlen_r  <= qlen_nxt;
    out_r   <= out_nxt;
  end

  // Sample store
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= store_wdata;
    end
    if (store_re) begin
      store_q_r <= store_mem[store_raddr];
    end
  end

  // Presence map
  always_ff @(posedge clk) begin
    if (pmap_we) begin
      pmap_mem[pmap_waddr] <= pmap_wdata;
    end
    if (pmap_re) begin
      pmap_q_r <= pmap_mem[pmap_raddr];
    end
  end

  assign stat.sweeping = (state_r == ST_SWEEP);
  assign res_valid     = out_valid_r;
  assign res           = out_r;

endmodule

FILE: rtl/core/bfr_checker.sv
`include "burst_fragment_reassembler_macros.svh"

module bfr_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata
);

  `BFR_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `BFR_ASSERT(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata), "result changed while stalled")
  `BFR_ASSERT(a_queue_bound, clk, rst_n, out_tvalid |-> out_tdata[54:52] <= 3'd4, "queued captures above queue size")
  `BFR_ASSERT(a_read_zero, clk, rst_n, out_tvalid && !out_tdata[51] |-> out_tdata[50:3] == 48'd0, "read data without a valid read")
  `BFR_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_tvalid, "result shown after reset")

endmodule

bind burst_fragment_reassembler bfr_checker u_bfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // Codes the block treats as no operation.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int SETTLE_CYCLES = 1200;
  localparam int SQUEEZE_CYCLES = 3000;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] total;
    logic [15:0] start;
    logic [15:0] count;
    logic [15:0] size;
    logic [15:0] pa;
    logic [15:0] pb;
    logic [15:0] ang;
    logic [9:0]  idx;
    bit          typed;
    logic        t_perr;
    logic        t_valid;
    logic [2:0]  t_queued;
    logic [31:0] t_err;
    logic [31:0] t_frm;
  } beat_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [2:0]   cfg_wr_data = 3'd0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;

  burst_fragment_reassembler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock with a 2 ns period.
  initial begin
    forever #1 clk = ~clk;
  end

  // Reassembly state as the block should hold it.
  logic [47:0] cap_store [0:bfr_pkg::NUM_BANKS*bfr_pkg::CAPTURE_DEPTH-1];
  logic [bfr_pkg::CAPTURE_DEPTH-1:0] slot_seen;
  int unsigned asm_len, asm_rcvd, frm_base, frm_left, asm_bank;
  bit          frm_open;
  int unsigned q_bank [bfr_pkg::QUEUE_SLOTS];
  int unsigned q_len [bfr_pkg::QUEUE_SLOTS];
  int unsigned q_head, q_fill, keep_limit;
  logic [31:0] bad_hdrs, all_hdrs;

  beat_t stim_q[$];
  bfr_pkg::res_t status_q[$];
  beat_t cur_beat;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  bit    squeeze_on = 0;
  bit    squeeze_done = 0;
  int    squeeze_cnt = 0;
  int    cycles = 0;
  int    mismatches = 0;
  int    n_items = 0;
  int    n_done = 0;
  int    n_drop = 0;
  int    n_hits = 0;
  int    n_beats = 0;

  function automatic logic [127:0] pack_beat(beat_t b);
    return {6'd0, b.idx, b.ang, b.pb, b.pa, b.size, b.count, b.start, b.total};
  endfunction

  function automatic int unsigned clamped_limit();
    if (keep_limit < 1) return 1;
    if (keep_limit > bfr_pkg::QUEUE_SLOTS) return bfr_pkg::QUEUE_SLOTS;
    return keep_limit;
  endfunction

  task automatic clear_assembly();
    slot_seen = '0;
    asm_len = 0;
    asm_rcvd = 0;
  endtask

  task automatic reset_model();
    clear_assembly();
    frm_base = 0;
    frm_left = 0;
    frm_open = 0;
    asm_bank = 0;
    q_head = 0;
    q_fill = 0;
    bad_hdrs = 0;
    all_hdrs = 0;
    keep_limit = 4;
    for (int i = 0; i < bfr_pkg::QUEUE_SLOTS; i++) begin
      q_bank[i] = 0;
      q_len[i] = 0;
    end
  endtask

  // Lowest bank that no queued capture holds.
  task automatic choose_bank();
    bit used;
    for (int b = 0; b <= bfr_pkg::QUEUE_SLOTS; b++) begin
      used = 0;
      for (int i = 0; i < q_fill; i++)
        if (q_bank[(q_head + i) % bfr_pkg::QUEUE_SLOTS] == b) used = 1;
      if (!used) begin
        asm_bank = b;
        return;
      end
    end
    asm_bank = 0;
  endtask

  // Advances the state by one beat and gives the status beat it causes.
  task automatic reassemble(input beat_t b, output bfr_pkg::res_t r);
    int unsigned need, slot, pos;
    logic [47:0] w;
    r = '0;
    case (b.cmd)
      bfr_pkg::CMD_HDR: begin
        need = bfr_pkg::HDR_BYTES + 6 * int'(b.count);
        all_hdrs++;
        if (b.total == 0 || b.count == 0 || need > b.size ||
            int'(b.start) + int'(b.count) > int'(b.total) ||
            b.total > bfr_pkg::CAPTURE_DEPTH) begin
          bad_hdrs++;
          r.perr = 1'b1;
          frm_open = 0;
          frm_left = 0;
        end else begin
          if (asm_len != b.total) begin
            clear_assembly();
            asm_len = b.total;
          end
          frm_base = b.start;
          frm_left = b.count;
          frm_open = 1;
        end
      end
      bfr_pkg::CMD_SMP: begin
        if (frm_open && frm_left > 0 && frm_base < bfr_pkg::CAPTURE_DEPTH) begin
          slot = asm_bank * bfr_pkg::CAPTURE_DEPTH + frm_base;
          cap_store[slot] = {b.ang, b.pb, b.pa};
          if (!slot_seen[frm_base]) begin
            slot_seen[frm_base] = 1'b1;
            asm_rcvd++;
          end
          frm_base++;
          frm_left--;
          if (frm_left == 0) begin
            frm_open = 0;
            if (asm_rcvd == asm_len) begin
              if (q_fill >= clamped_limit()) begin
                q_head = (q_head + 1) % bfr_pkg::QUEUE_SLOTS;
                q_fill--;
                r.dropped = 1'b1;
              end
              pos = (q_head + q_fill) % bfr_pkg::QUEUE_SLOTS;
              q_bank[pos] = asm_bank;
              q_len[pos] = asm_len;
              q_fill++;
              r.done = 1'b1;
              clear_assembly();
              choose_bank();
            end
          end
        end
      end
      bfr_pkg::CMD_RD: begin
        if (q_fill > 0 && b.idx < q_len[q_head]) begin
          w = cap_store[q_bank[q_head] * bfr_pkg::CAPTURE_DEPTH + b.idx];
          r.pa = w[15:0];
          r.pb = w[31:16];
          r.ang = w[47:32];
          r.read_valid = 1'b1;
        end
      end
      bfr_pkg::CMD_REL: begin
        if (q_fill > 0) begin
          q_head = (q_head + 1) % bfr_pkg::QUEUE_SLOTS;
          q_fill--;
        end
      end
      bfr_pkg::CMD_ABT: begin
        clear_assembly();
        frm_base = 0;
        frm_left = 0;
        frm_open = 0;
        q_head = 0;
        q_fill = 0;
        asm_bank = 0;
      end
      default: ;
    endcase
    r.queued = 3'(q_fill);
    r.oldest_len = (q_fill > 0) ? 11'(q_len[q_head]) : 11'd0;
    r.rcvd = 11'(asm_rcvd);
    r.err_total = bad_hdrs;
    r.frm_total = all_hdrs;
  endtask

  // Sender: offers the next beat or idles.
  always @(posedge clk) begin : sender
    beat_t b;
    if (rst_n && (!in_tvalid || in_tready)) begin
      if (stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        b = stim_q[0];
        stim_q.delete(0);
        in_tvalid <= 1'b1;
        in_tdata <= pack_beat(b);
        in_tuser <= b.cmd;
        cur_beat <= b;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted in cycles.
  always @(posedge clk) begin
    if (squeeze_on && !squeeze_done) begin
      squeeze_cnt <= squeeze_cnt + 1;
      if (squeeze_cnt == SQUEEZE_CYCLES - 1) squeeze_done <= 1'b1;
    end
  end

  // Receiver: random stalls, plus the long hold-off while input keeps coming.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (squeeze_on && !squeeze_done) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Predicts at every accepted input beat and checks every status beat.
  always @(posedge clk) begin : scoreboard
    bfr_pkg::res_t want, got;
    if (rst_n) begin
      if (cfg_wr_en) keep_limit = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        reassemble(cur_beat, want);
        if (cur_beat.typed) begin
          want.perr = cur_beat.t_perr;
          want.read_valid = cur_beat.t_valid;
          want.queued = cur_beat.t_queued;
          want.err_total = cur_beat.t_err;
          want.frm_total = cur_beat.t_frm;
        end
        n_done += want.done;
        n_drop += want.dropped;
        n_hits += want.read_valid;
        status_q = {status_q, want};
      end
      if (out_tvalid && out_tready) begin
        got = bfr_pkg::res_t'(out_tdata[140:0]);
        n_beats++;
        if (status_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected status beat %h", out_tdata);
          mismatches++;
        end else begin
          want = status_q[0];
          status_q.delete(0);
          if (got.perr !== want.perr || got.done !== want.done ||
              got.dropped !== want.dropped || got.pa !== want.pa ||
              got.pb !== want.pb || got.ang !== want.ang ||
              got.read_valid !== want.read_valid || got.queued !== want.queued ||
              got.oldest_len !== want.oldest_len || got.rcvd !== want.rcvd ||
              got.err_total !== want.err_total || got.frm_total !== want.frm_total ||
              out_tdata[143:141] !== 3'd0) begin
            if (mismatches < 10) begin
              $display("status mismatch at beat %0d", n_beats);
              $display("  expected %h", want);
              $display("  actual   %h", got);
            end
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic put(logic [2:0] cmd, logic [15:0] total, logic [15:0] start,
                     logic [15:0] count, logic [15:0] size, logic [9:0] idx);
    beat_t b;
    b = '{default: '0};
    b.cmd = cmd;
    b.total = total;
    b.start = start;
    b.count = count;
    b.size = size;
    b.pa = 16'($urandom());
    b.pb = 16'($urandom());
    b.ang = 16'($urandom());
    b.idx = idx;
    stim_q = {stim_q, b};
    n_items++;
  endtask

  task automatic put_header(int unsigned total, int unsigned start, int unsigned count);
    int unsigned size;
    size = bfr_pkg::HDR_BYTES + 6 * count;
    if ($urandom_range(1)) size += $urandom_range(0, 40);
    put(bfr_pkg::CMD_HDR, 16'(total), 16'(start), 16'(count), 16'(size), '0);
  endtask

  // One capture sent as frames, with truncated and repeated frames mixed in.
  task automatic send_capture(int unsigned total);
    int unsigned pos, cnt, sent, cap, st;
    pos = 0;
    cap = (total > 64) ? total : 4;
    while (pos < total) begin
      cnt = $urandom_range(1, (total - pos < cap) ? total - pos : cap);
      st = pos;
      if (pos > 0 && $urandom_range(9) == 0) st = $urandom_range(0, pos - 1);
      if (st + cnt > total) cnt = total - st;
      put_header(total, st, cnt);
      sent = ($urandom_range(9) == 0) ? $urandom_range(0, cnt - 1) : cnt;
      for (int i = 0; i < sent; i++) put(bfr_pkg::CMD_SMP, '0, '0, '0, '0, '0);
      if (st == pos) pos += sent;
      if ($urandom_range(7) == 0)
        put(bfr_pkg::CMD_RD, '0, '0, '0, '0, 10'($urandom_range(0, 7)));
    end
  endtask

  // Mostly well-formed captures; the rest reads, releases, aborts and noise.
  task automatic random_traffic(int budget, bit with_big);
    int r;
    int stop;
    stop = n_items + budget;
    if (with_big) send_capture(bfr_pkg::CAPTURE_DEPTH);
    while (n_items < stop) begin
      r = $urandom_range(99);
      if (r < 50) send_capture(($urandom_range(9) == 0) ? $urandom_range(7, 40)
                                                        : $urandom_range(1, 6));
      else if (r < 68) put(bfr_pkg::CMD_RD, '0, '0, '0, '0, 10'($urandom_range(0, 9)));
      else if (r < 72) put(bfr_pkg::CMD_RD, '0, '0, '0, '0, 10'($urandom()));
      else if (r < 80) put(bfr_pkg::CMD_REL, '0, '0, '0, '0, '0);
      else if (r < 82) put(bfr_pkg::CMD_ABT, '0, '0, '0, '0, '0);
      else if (r < 88) put(bfr_pkg::CMD_HDR, 16'($urandom_range(0, 8)),
                           16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                           16'($urandom_range(0, 60)), '0);
      else if (r < 93) put(bfr_pkg::CMD_HDR, 16'($urandom()), 16'($urandom()),
                           16'($urandom()), 16'($urandom()), '0);
      else if (r < 96) put(bfr_pkg::CMD_SMP, '0, '0, '0, '0, '0);
      else put(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 16'($urandom()),
               16'($urandom()), 16'($urandom()), 16'($urandom()), 10'($urandom()));
    end
  endtask

  task automatic wait_idle();
    while (stim_q.size() > 0 || in_tvalid || status_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [2:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Directed rows: cmd, total, start, count, size, pa, pb, ang, idx,
  // typed expectation where it is obvious.
  beat_t dir_tab [] = '{
    // Read with empty queue right after reset.
    '{bfr_pkg::CMD_RD, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
    // Rejected headers: zero total, zero count, short payload, overrun, too big.
    '{bfr_pkg::CMD_HDR, 0, 0, 1, 12, 0, 0, 0, 0, 1, 1, 0, 0, 1, 1},
    '{bfr_pkg::CMD_HDR, 2, 0, 0, 12, 0, 0, 0, 0, 1, 1, 0, 0, 2, 2},
    '{bfr_pkg::CMD_HDR, 2, 0, 1, 11, 0, 0, 0, 0, 1, 1, 0, 0, 3, 3},
    '{bfr_pkg::CMD_HDR, 2, 2, 1, 12, 0, 0, 0, 0, 1, 1, 0, 0, 4, 4},
    '{bfr_pkg::CMD_HDR, 1025, 0, 1, 12, 0, 0, 0, 0, 1, 1, 0, 0, 5, 5},
    '{bfr_pkg::CMD_HDR, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 0, 0, 10'h3ff,
      1, 1, 0, 0, 6, 6},
    // Sample with no open frame.
    '{bfr_pkg::CMD_SMP, 0, 0, 0, 0, 16'h1234, 16'h5678, 16'h9abc, 0, 0, 0, 0, 0, 0, 0},
    '{bfr_pkg::CMD_HDR, 2, 0, 2, 18, 0, 0, 0, 0, 1, 0, 0, 0, 6, 7},
    '{bfr_pkg::CMD_SMP, 0, 0, 0, 0, 16'h8000, 16'h7fff, 16'h0000, 0, 0, 0, 0, 0, 0, 0},
    '{bfr_pkg::CMD_SMP, 0, 0, 0, 0, 16'h7fff, 16'h8000, 16'hffff, 0, 0, 0, 0, 0, 0, 0},
    '{bfr_pkg::CMD_RD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{bfr_pkg::CMD_RD, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0},
    '{bfr_pkg::CMD_RD, 0, 0, 0, 0, 0, 0, 0, 2, 0, 0, 0, 0, 0, 0},
    '{bfr_pkg::CMD_RD, 0, 0, 0, 0, 0, 0, 0, 10'h3ff, 0, 0, 0, 0, 0, 0},
    '{bfr_pkg::CMD_HDR, 1, 0, 1, 12, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{bfr_pkg::CMD_SMP, 0, 0, 0, 0, 16'hffff, 16'h0001, 16'h8000, 0, 0, 0, 0, 0, 0, 0},
    // A header arriving in the middle of a frame takes over.
    '{bfr_pkg::CMD_HDR, 3, 0, 3, 24, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{bfr_pkg::CMD_SMP, 0, 0, 0, 0, 16'h0001, 16'hfffe, 16'h0101, 0, 0, 0, 0, 0, 0, 0},
    '{bfr_pkg::CMD_HDR, 3, 1, 2, 16'hffff, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{bfr_pkg::CMD_SMP, 0, 0, 0, 0, 16'h0002, 16'hfffd, 16'h0202, 0, 0, 0, 0, 0, 0, 0},
    '{bfr_pkg::CMD_SMP, 0, 0, 0, 0, 16'h0003, 16'hfffc, 16'h0303, 0, 0, 0, 0, 0, 0, 0},
    '{bfr_pkg::CMD_REL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{CMD_SPARE_LO, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
      16'hffff, 10'h3ff, 0, 0, 0, 0, 0, 0},
    '{bfr_pkg::CMD_ABT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{CMD_SPARE_HI, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
  };

  // Phase plan: queue limit, sender idle and receiver stall percentages.
  int ph_limit [6] = '{1, 0, 7, 2, 3, 4};
  int ph_send  [6] = '{0, 45, 0, 22, 45, 0};
  int ph_recv  [6] = '{0, 0, 45, 22, 45, 0};

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows at the reset queue limit.
    foreach (dir_tab[i]) begin
      stim_q = {stim_q, dir_tab[i]};
      n_items++;
    end
    wait_idle();

    // Random phases over several queue limits and idle patterns.
    for (int p = 0; p < 6; p++) begin
      write_limit(3'(ph_limit[p]));
      send_idle_pct = ph_send[p];
      recv_stall_pct = ph_recv[p];
      if (p == 5) squeeze_on = 1;
      random_traffic(100, p == 2);
      wait_idle();
    end

    if (status_q.size() > 0) mismatches++;
    $display("Ran %0d beats over six queue limits and idle patterns.", n_items);
    $display("Captures completed %0d, dropped %0d, read hits %0d, mismatches %0d.",
             n_done, n_drop, n_hits, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/bfr_pkg.sv
rtl/core/bfr_front.sv
rtl/core/bfr_queue.sv
rtl/core/bfr_back.sv
rtl/core/burst_fragment_reassembler.sv
rtl/core/bfr_checker.sv
test/tb_top.sv
